// File: src/slc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slc_pkg;

  // Width of every line counter, including the block comment line count.
  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned CHAR_WIDTH  = 16;
  localparam int unsigned LINES_WIDTH = 32;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [CHAR_WIDTH-1:0]  char_t;

  localparam char_t CH_SLASH = 16'h002F;
  localparam char_t CH_STAR  = 16'h002A;
  localparam char_t CH_LF    = 16'h000A;
  localparam char_t CH_CR    = 16'h000D;
  localparam char_t CH_TAB   = 16'h0009;
  localparam char_t CH_SPACE = 16'h0020;
  localparam char_t CH_NUL   = 16'h0000;

  // The four counts of one file, as handed from the core to the result register.
  typedef struct packed {
    cnt_t total;
    cnt_t code;
    cnt_t comment;
    cnt_t blank;
  } slc_counts_t;

  // Adds two counts and clamps at the all-ones value.
  function automatic cnt_t sat_add(cnt_t a, cnt_t b);
    logic [COUNT_WIDTH:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

// File: src/slc_core.sv
`timescale 1ns / 1ps
`default_nettype none

module slc_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                fire_i,
  input  wire slc_pkg::char_t      code_unit_i,
  input  wire logic                has_char_i,
  input  wire logic                end_of_file_i,
  output slc_pkg::slc_counts_t     counts_o
);
  import slc_pkg::*;

  cnt_t  total_q, total_d, code_q, code_d, comment_q, comment_d, blank_q, blank_d;
  cnt_t  block_q, block_d;
  logic  armed_q, armed_d, line_blank_q, line_blank_d;
  logic  pending_q, pending_d, skip_q, skip_d;
  char_t prev_q, prev_d;

  always_comb begin
    cnt_t  tot, cod, com, blk, bln;
    logic  armed, lblank, pend, skip;
    char_t prev;
    tot    = total_q;
    cod    = code_q;
    com    = comment_q;
    bln    = blank_q;
    blk    = block_q;
    armed  = armed_q;
    lblank = line_blank_q;
    pend   = pending_q;
    skip   = skip_q;
    prev   = prev_q;

    if (fire_i && has_char_i) begin
      if (skip_q) begin
        // Inside a line comment: only the newline that ends it matters.
        if (code_unit_i == CH_LF) begin
          skip = 1'b0;
        end
      end else begin
        prev = code_unit_i;
        if (code_unit_i == CH_SLASH) begin
          lblank = 1'b0;
          if (prev_q == CH_SLASH) begin
            if (armed_q) begin
              // Line comment opener: it ends the line as a comment line.
              com    = sat_add(com, cnt_t'(1));
              armed  = 1'b0;
              skip   = 1'b1;
              tot    = sat_add(tot, cnt_t'(1));
              lblank = 1'b1;
              if (pend) begin
                cod  = sat_add(cod, cnt_t'(1));
                pend = 1'b0;
              end
              prev = CH_LF;
            end
          end else if (prev_q == CH_STAR) begin
            com = sat_add(com, blk);
            blk = '0;
          end else if (blk == '0) begin
            armed = 1'b1;
          end
        end else if (code_unit_i == CH_STAR) begin
          lblank = 1'b0;
          if (prev_q == CH_SLASH) begin
            blk = sat_add(blk, cnt_t'(1));
          end
          armed = 1'b0;
        end else if (code_unit_i == CH_LF) begin
          if (blk != '0) begin
            blk = sat_add(blk, cnt_t'(1));
          end else if (lblank) begin
            bln = sat_add(bln, cnt_t'(1));
          end else if (pend) begin
            cod  = sat_add(cod, cnt_t'(1));
            pend = 1'b0;
          end
          tot    = sat_add(tot, cnt_t'(1));
          lblank = 1'b1;
        end else if (code_unit_i inside {CH_CR, CH_TAB, CH_SPACE, CH_NUL}) begin
          lblank = lblank;
        end else begin
          if (blk == '0) begin
            pend = 1'b1;
          end
          lblank = 1'b0;
        end
      end
    end

    counts_o.total   = tot;
    counts_o.code    = cod;
    counts_o.comment = com;
    counts_o.blank   = bln;

    if (fire_i && end_of_file_i) begin
      total_d      = '0;
      code_d       = '0;
      comment_d    = '0;
      blank_d      = '0;
      block_d      = '0;
      armed_d      = 1'b0;
      line_blank_d = 1'b1;
      pending_d    = 1'b0;
      skip_d       = 1'b0;
      prev_d       = CH_NUL;
    end else begin
      total_d      = tot;
      code_d       = cod;
      comment_d    = com;
      blank_d      = bln;
      block_d      = blk;
      armed_d      = armed;
      line_blank_d = lblank;
      pending_d    = pend;
      skip_d       = skip;
      prev_d       = prev;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q      <= '0;
      code_q       <= '0;
      comment_q    <= '0;
      blank_q      <= '0;
      block_q      <= '0;
      armed_q      <= 1'b0;
      line_blank_q <= 1'b1;
      pending_q    <= 1'b0;
      skip_q       <= 1'b0;
      prev_q       <= CH_NUL;
    end else begin
      total_q      <= total_d;
      code_q       <= code_d;
      comment_q    <= comment_d;
      blank_q      <= blank_d;
      block_q      <= block_d;
      armed_q      <= armed_d;
      line_blank_q <= line_blank_d;
      pending_q    <= pending_d;
      skip_q       <= skip_d;
      prev_q       <= prev_d;
    end
  end

endmodule

`default_nettype wire

// File: src/source_line_classifier.sv
// Flow: an accepted item is held in the input register until the core takes it; the
// counts of an end-of-file item are loaded into the result register when it is taken
// and are offered on the result port from there.
// Throughput: one item per cycle while the input does not stall, set by the update of the line state.
// An end-of-file item waits in the input register only while a result is stalled.
// Reset (rst_ni, asynchronous, active low) empties both registers and clears all counts.
`timescale 1ns / 1ps
`default_nettype none

module source_line_classifier (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [slc_pkg::CHAR_WIDTH-1:0] code_unit_i,
  input  wire logic                          has_char_i,
  input  wire logic                          end_of_file_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [slc_pkg::LINES_WIDTH-1:0]    total_lines_o,
  output logic [slc_pkg::LINES_WIDTH-1:0]    code_lines_o,
  output logic [slc_pkg::LINES_WIDTH-1:0]    comment_lines_o,
  output logic [slc_pkg::LINES_WIDTH-1:0]    blank_lines_o
);
  import slc_pkg::*;

  // Input register: holds one item until the core takes it.
  logic  in_valid_q;
  char_t code_q;
  logic  has_char_q, eof_q;

  // Result register: holds the counts of one file until the consumer takes them.
  logic        out_valid_q;
  slc_counts_t result_q;
  slc_counts_t counts;

  logic out_free, take;

  // The result register can be loaded when it is empty or being emptied this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  // An ordinary character is always consumed; an end-of-file item needs room for
  // its result, otherwise it stays put and the input side stalls.
  assign take       = in_valid_q && (!eof_q || out_free);
  assign in_stall_o = in_valid_q && !take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      code_q     <= code_unit_i;
      has_char_q <= has_char_i;
      eof_q      <= end_of_file_i;
    end
  end

  // The core holds the line state and produces the counts as they stand after
  // the current character.
  slc_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (take),
    .code_unit_i   (code_q),
    .has_char_i    (has_char_q),
    .end_of_file_i (eof_q),
    .counts_o      (counts)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= take && eof_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && eof_q) begin
      result_q <= counts;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign total_lines_o   = LINES_WIDTH'(result_q.total);
  assign code_lines_o    = LINES_WIDTH'(result_q.code);
  assign comment_lines_o = LINES_WIDTH'(result_q.comment);
  assign blank_lines_o   = LINES_WIDTH'(result_q.blank);

endmodule

`default_nettype wire

// File: src/slc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module slc_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_stall_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic [slc_pkg::LINES_WIDTH-1:0] total_lines_o,
  input wire logic [slc_pkg::LINES_WIDTH-1:0] code_lines_o,
  input wire logic [slc_pkg::LINES_WIDTH-1:0] comment_lines_o,
  input wire logic [slc_pkg::LINES_WIDTH-1:0] blank_lines_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its counts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(total_lines_o) && $stable(code_lines_o)
      && $stable(comment_lines_o) && $stable(blank_lines_o))
    else $error("result counts changed while stalled");

  // The input side only stalls behind a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  // Every code line also ends a line, so code lines never exceed total lines.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> code_lines_o <= total_lines_o)
    else $error("code lines exceed total lines");

  // Every blank line ends a line as well.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> blank_lines_o <= total_lines_o)
    else $error("blank lines exceed total lines");

endmodule

bind source_line_classifier slc_checker u_slc_checker (.*);

`default_nettype wire

// File: tb/slc_line_count_checker.sv
`timescale 1ns / 1ps

module slc_line_count_checker (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  input  wire logic                         in_stall_i,
  input  wire slc_pkg::char_t               code_unit_i,
  input  wire logic                         has_char_i,
  input  wire logic                         end_of_file_i,
  input  wire logic                         out_valid_i,
  input  wire logic                         out_stall_i,
  input  wire logic [slc_pkg::LINES_WIDTH-1:0] total_lines_i,
  input  wire logic [slc_pkg::LINES_WIDTH-1:0] code_lines_i,
  input  wire logic [slc_pkg::LINES_WIDTH-1:0] comment_lines_i,
  input  wire logic [slc_pkg::LINES_WIDTH-1:0] blank_lines_i,
  output int                                mismatches_o,
  output int                                outstanding_o
);

  import slc_pkg::*;

  // Line state of the file that is being scanned.
  typedef struct {
    cnt_t  total;
    cnt_t  code;
    cnt_t  comment;
    cnt_t  blank;
    cnt_t  block_lines;
    logic  armed;
    logic  blank_line;
    logic  code_pending;
    logic  skipping;
    char_t prev;
  } line_state_t;

  line_state_t tracked;
  slc_counts_t expected_counts_q[$];

  function automatic cnt_t clamp_add(cnt_t a, cnt_t b);
    logic [COUNT_WIDTH:0] wide;
    wide = {1'b0, a} + {1'b0, b};
    if (wide[COUNT_WIDTH]) return '1;
    return wide[COUNT_WIDTH-1:0];
  endfunction

  function automatic line_state_t fresh_state();
    line_state_t s;
    s.total        = '0;
    s.code         = '0;
    s.comment      = '0;
    s.blank        = '0;
    s.block_lines  = '0;
    s.armed        = 1'b0;
    s.blank_line   = 1'b1;
    s.code_pending = 1'b0;
    s.skipping     = 1'b0;
    s.prev         = CH_NUL;
    return s;
  endfunction

  function automatic line_state_t next_state(line_state_t s, char_t c);
    if (s.skipping) begin
      if (c == CH_LF) s.skipping = 1'b0;
      return s;
    end
    if (c == CH_SLASH) begin
      s.blank_line = 1'b0;
      if (s.prev == CH_SLASH) begin
        if (s.armed) begin
          // Line comment: it ends the line here and the rest is skipped.
          s.comment    = clamp_add(s.comment, 1);
          s.total      = clamp_add(s.total, 1);
          s.armed      = 1'b0;
          s.skipping   = 1'b1;
          s.blank_line = 1'b1;
          if (s.code_pending) begin
            s.code         = clamp_add(s.code, 1);
            s.code_pending = 1'b0;
          end
          s.prev = CH_LF;
          return s;
        end
      end else if (s.prev == CH_STAR) begin
        s.comment     = clamp_add(s.comment, s.block_lines);
        s.block_lines = '0;
      end else if (s.block_lines == '0) begin
        s.armed = 1'b1;
      end
    end else if (c == CH_STAR) begin
      s.blank_line = 1'b0;
      if (s.prev == CH_SLASH) s.block_lines = clamp_add(s.block_lines, 1);
      s.armed = 1'b0;
    end else if (c == CH_LF) begin
      if (s.block_lines != '0) begin
        s.block_lines = clamp_add(s.block_lines, 1);
      end else if (s.blank_line) begin
        s.blank = clamp_add(s.blank, 1);
      end else if (s.code_pending) begin
        s.code         = clamp_add(s.code, 1);
        s.code_pending = 1'b0;
      end
      s.total      = clamp_add(s.total, 1);
      s.blank_line = 1'b1;
    end else if (!(c == CH_CR || c == CH_TAB || c == CH_SPACE || c == CH_NUL)) begin
      if (s.block_lines == '0) s.code_pending = 1'b1;
      s.blank_line = 1'b0;
    end
    s.prev = c;
    return s;
  endfunction

  task automatic check_field(input string label, input cnt_t want, input cnt_t got);
    if (want !== got) begin
      $display("%0t: %s lines mismatch, expected %0d, actual %0d", $time, label, want, got);
      mismatches_o = mismatches_o + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    slc_counts_t want;
    slc_counts_t done;
    if (!rst_ni) begin
      tracked = fresh_state();
      expected_counts_q.delete();
      mismatches_o  = 0;
      outstanding_o = 0;
    end else begin
      // A result leaves only after its end-of-file item has passed the input and result
      // registers, so the output side is checked before the input side updates the store.
      if (out_valid_i && !out_stall_i) begin
        if (expected_counts_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d/%0d", $time,
                   total_lines_i, code_lines_i, comment_lines_i, blank_lines_i);
          mismatches_o = mismatches_o + 1;
        end else begin
          want = expected_counts_q.pop_front();
          check_field("total", want.total, total_lines_i);
          check_field("code", want.code, code_lines_i);
          check_field("comment", want.comment, comment_lines_i);
          check_field("blank", want.blank, blank_lines_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (has_char_i) tracked = next_state(tracked, code_unit_i);
        if (end_of_file_i) begin
          done.total   = tracked.total;
          done.code    = tracked.code;
          done.comment = tracked.comment;
          done.blank   = tracked.blank;
          expected_counts_q.push_back(done);
          tracked = fresh_state();
        end
      end
      outstanding_o = expected_counts_q.size();
    end
  end

endmodule

// File: tb/tb_source_line_classifier.sv
`timescale 1ns / 1ps

// Top of the line classifier bench. This module only makes stimulus and gives the
// verdict: it feeds short C-like source files one character per item, idles and
// stalls both channels at random, and the checker beside the block predicts the
// four line counts of every file and compares them with what comes out.
module tb_source_line_classifier;

  import slc_pkg::*;

  // Generous bound on the whole run; a correct run needs a small fraction of it.
  localparam int CYCLE_LIMIT = 400000;
  // Target number of input items that carry a character or an end marker.
  localparam int ITEM_TARGET = 1150;
  // Cycles to wait after the last result so that a stray extra one is caught.
  localparam int SETTLE_CYCLES = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic  in_valid_i = 1'b0;
  char_t code_unit_i = '0;
  logic  has_char_i = 1'b0;
  logic  end_of_file_i = 1'b0;
  logic  out_stall_i = 1'b0;

  wire logic                   in_stall_o;
  wire logic                   out_valid_o;
  wire logic [LINES_WIDTH-1:0] total_lines_o;
  wire logic [LINES_WIDTH-1:0] code_lines_o;
  wire logic [LINES_WIDTH-1:0] comment_lines_o;
  wire logic [LINES_WIDTH-1:0] blank_lines_o;

  int mismatches;
  int pending_results;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int idle_pct = 15;
  int stall_pct = 83;
  // When nonzero, the receiver holds off for this many more cycles.
  int hold_off_cycles = 0;

  int items_sent = 0;
  int files_sent = 0;
  int cycle_count = 0;

  // Characters of the file that is about to be sent.
  char_t file_text[$];

  source_line_classifier dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .code_unit_i     (code_unit_i),
    .has_char_i      (has_char_i),
    .end_of_file_i   (end_of_file_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .total_lines_o   (total_lines_o),
    .code_lines_o    (code_lines_o),
    .comment_lines_o (comment_lines_o),
    .blank_lines_o   (blank_lines_o)
  );

  slc_line_count_checker checker_inst (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .code_unit_i     (code_unit_i),
    .has_char_i      (has_char_i),
    .end_of_file_i   (end_of_file_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .total_lines_i   (total_lines_o),
    .code_lines_i    (code_lines_o),
    .comment_lines_i (comment_lines_o),
    .blank_lines_i   (blank_lines_o),
    .mismatches_o    (mismatches),
    .outstanding_o   (pending_results)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count = cycle_count + 1;
    end
    $display("source_line_classifier verification failed");
    $finish;
  end

  // Receiver. The stall changes only at the falling edge. A requested hold-off is
  // counted down here at each falling edge, while the sender keeps going, so
  // a held result backs up into the input register and the block stalls its input.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_off_cycles = hold_off_cycles - 1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Offers one item and returns right after the rising edge that accepts it. The
  // sender may idle first; once valid is raised, the payload holds until accepted.
  task automatic send_item(input char_t unit, input logic has, input logic eof);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    code_unit_i   <= unit;
    has_char_i    <= has;
    end_of_file_i <= eof;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (has || eof) items_sent = items_sent + 1;
    if (eof) files_sent = files_sent + 1;
  endtask

  // Pauses the sender until every expected set of counts has come out.
  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results != 0) @(negedge clk_i);
  endtask

  function automatic char_t letter();
    return char_t'($urandom_range(8'h7a, 8'h61));
  endfunction

  function automatic char_t blank_char();
    case ($urandom_range(3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_CR;
      default: return CH_NUL;
    endcase
  endfunction

  // Any character at all, weighted toward the ones the classifier reacts to.
  // The full 16-bit draw makes every bit of the code unit take both values.
  function automatic char_t noise_char();
    case ($urandom_range(9))
      0, 1:    return CH_SLASH;
      2, 3:    return CH_STAR;
      4:       return CH_LF;
      5:       return blank_char();
      6:       return letter();
      7:       return 16'hFFFF;
      default: return char_t'($urandom);
    endcase
  endfunction

  // Builds a short file from pieces: code lines, blank lines, line comments, block
  // comments (sometimes nested, sometimes left open) and a little raw noise. Lines
  // are mostly, but not always, closed by a newline.
  task automatic build_file();
    int pieces;
    int n;
    file_text.delete();
    pieces = $urandom_range(6, 1);
    repeat (pieces) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          n = $urandom_range(4, 1);
          repeat (n) file_text.push_back(letter());
          if ($urandom_range(3) == 0) begin
            file_text.push_back(blank_char());
            file_text.push_back(letter());
          end
          if ($urandom_range(9) != 0) file_text.push_back(CH_LF);
        end
        3: begin
          repeat ($urandom_range(2)) file_text.push_back(blank_char());
          file_text.push_back(CH_LF);
        end
        4, 5: begin
          if ($urandom_range(1)) file_text.push_back(letter());
          file_text.push_back(CH_SLASH);
          file_text.push_back(CH_SLASH);
          repeat ($urandom_range(3)) file_text.push_back(noise_char());
          if ($urandom_range(9) != 0) file_text.push_back(CH_LF);
        end
        6, 7: begin
          file_text.push_back(CH_SLASH);
          file_text.push_back(CH_STAR);
          repeat ($urandom_range(6)) begin
            case ($urandom_range(4))
              0: file_text.push_back(CH_LF);
              1: begin
                // A nested opener adds one more line to the comment.
                file_text.push_back(CH_SPACE);
                file_text.push_back(CH_SLASH);
                file_text.push_back(CH_STAR);
              end
              2: file_text.push_back(noise_char());
              default: file_text.push_back(letter());
            endcase
          end
          if ($urandom_range(6) != 0) begin
            file_text.push_back(CH_STAR);
            file_text.push_back(CH_SLASH);
          end
          if ($urandom_range(1)) file_text.push_back(CH_LF);
        end
        default: begin
          repeat ($urandom_range(3, 1)) file_text.push_back(noise_char());
        end
      endcase
    end
  endtask

  // Sends the built file. Empty items are sprinkled in, and the end marker either
  // rides on the last character or comes as a bare item of its own.
  task automatic send_file();
    int   k;
    int   last;
    logic merge_eof;
    last = file_text.size() - 1;
    merge_eof = 1'($urandom_range(1));
    for (k = 0; k <= last; k = k + 1) begin
      if ($urandom_range(24) == 0) send_item(char_t'($urandom), 1'b0, 1'b0);
      send_item(file_text[k], 1'b1, merge_eof && (k == last));
    end
    if (!merge_eof) send_item(char_t'($urandom), 1'b0, 1'b1);
    // Now and then an empty file right after, which must give all zeros.
    if ($urandom_range(29) == 0) send_item(char_t'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    logic drained_mid;
    drained_mid = 1'b0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. A line comment after code credits the code and counts the
    // line; the newline that ends the skip is not counted again. The counts then
    // go out on a bare end marker with every code unit bit set.
    send_item(char_t'("x"), 1'b1, 1'b0);
    send_item(CH_SLASH, 1'b1, 1'b0);
    send_item(CH_SLASH, 1'b1, 1'b0);
    send_item(char_t'("c"), 1'b1, 1'b0);
    send_item(CH_LF, 1'b1, 1'b0);
    send_item(16'hFFFF, 1'b0, 1'b1);

    // A block comment with a nested opener and a newline inside, a newline after its
    // closer, a stray closer outside any comment, and an unfinished last line that ends
    // on the same item as the end marker.
    send_item(CH_SLASH, 1'b1, 1'b0);
    send_item(CH_STAR, 1'b1, 1'b0);
    send_item(CH_SPACE, 1'b1, 1'b0);
    send_item(CH_SLASH, 1'b1, 1'b0);
    send_item(CH_STAR, 1'b1, 1'b0);
    send_item(CH_LF, 1'b1, 1'b0);
    send_item(CH_STAR, 1'b1, 1'b0);
    send_item(CH_SLASH, 1'b1, 1'b0);
    send_item(CH_LF, 1'b1, 1'b0);
    send_item(CH_STAR, 1'b1, 1'b0);
    send_item(CH_SLASH, 1'b1, 1'b0);
    send_item(char_t'("q"), 1'b1, 1'b1);

    // An empty item, a line of nothing but whitespace, and a block comment that is
    // still open at the end of the file, whose lines are dropped.
    send_item(16'hFFFF, 1'b0, 1'b0);
    send_item(CH_TAB, 1'b1, 1'b0);
    send_item(CH_CR, 1'b1, 1'b0);
    send_item(CH_NUL, 1'b1, 1'b0);
    send_item(CH_LF, 1'b1, 1'b0);
    send_item(CH_SLASH, 1'b1, 1'b0);
    send_item(CH_STAR, 1'b1, 1'b1);

    // Random part. It opens with a long receiver hold-off so that results pile up
    // and the input side backs up while files keep coming.
    hold_off_cycles = 80;
    while (items_sent < ITEM_TARGET || files_sent < 45) begin
      if (items_sent < ITEM_TARGET / 3) begin
        idle_pct  = 15;
        stall_pct = 83;
      end else if (items_sent < 2 * ITEM_TARGET / 3) begin
        idle_pct  = 83;
        stall_pct = 15;
      end else begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      // Once, halfway through, the sender stops until the block has drained.
      if (!drained_mid && items_sent >= ITEM_TARGET / 2) begin
        wait_for_results();
        drained_mid = 1'b1;
      end
      build_file();
      send_file();
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_results == 0) begin
      $display("source_line_classifier verification clean");
    end else begin
      $display("source_line_classifier verification failed");
    end
    $finish;
  end

endmodule
